// ===== design/plst_pkg.sv =====
package plst_pkg;

   localparam int CAPACITY = 16;

   localparam int MODE_W   = 3;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 9;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef logic signed [VALUE_W-1:0] value_type;

   // per-cell load selects, at most one high in a cycle
   typedef struct packed {
      logic load_val;
      logic load_left;
      logic load_right;
   } plst_cell_ctl_type;

endpackage

// ===== design/positional_list_store_core.sv =====
// channel  direction  handshake           payload
// req      in         req_valid/req_stall mode, position, value_in
// rsp      out        rsp_valid/rsp_stall status, value_out, found_position, length
//
// one item per stall-free cycle; registered result shows the cycle after transfer
// the row of cells updates together: shift up, shift down, write or hold per cell
// a new item is taken while the current result is taken in the same cycle
// reset clears the length and the result valid; cell contents stay undefined
// req_stall is high only while an undelivered result is stalled
module positional_list_store_core
   import plst_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VALUE_W-1:0]  req_value_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_value_out,
   output logic [POS_W-1:0]           rsp_found_position,
   output logic [LEN_W-1:0]           rsp_length
);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   value_type           value_out_ff, value_out_in;
   logic [POS_W-1:0]    found_ff, found_in;

   value_type           cell_q [CAPACITY];
   logic [CAPACITY-1:0] cell_match;
   plst_cell_ctl_type   cell_ctl [CAPACITY];

   logic                accept;
   logic [LEN_W-1:0]    pos9, cnt9;
   logic [POS_W-1:0]    pos_m1;
   logic [IDX_W-1:0]    sel_idx;
   logic                pos_zero, ins_bad, rd_bad, is_full;
   logic                ins_ok, del_ok, upd_ok;
   logic [CAPACITY-1:0] hit_vec;
   logic                any_hit;
   logic [POS_W-1:0]    first_hit;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pos9     = {1'b0, req_position};
   assign cnt9     = LEN_W'(count_ff);
   assign pos_zero = (req_position == '0);
   assign ins_bad  = pos_zero || (pos9 > cnt9 + 1'b1);
   assign rd_bad   = pos_zero || (pos9 > cnt9);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign pos_m1   = req_position - 1'b1;
   assign sel_idx  = pos_m1[IDX_W-1:0];

   assign ins_ok = accept && (req_mode == MODE_INSERT) && !ins_bad && !is_full;
   assign del_ok = accept && (req_mode == MODE_DELETE) && !rd_bad;
   assign upd_ok = accept && (req_mode == MODE_UPDATE) && !rd_bad;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [LEN_W-1:0] cell_pos;   // 1-based position of this cell
         value_type        left_src, right_src;

         assign cell_pos = LEN_W'(gi + 1);

         if (gi == 0) begin : g_first
            assign left_src = cell_q[gi];
         end else begin : g_left
            assign left_src = cell_q[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_src = cell_q[gi];
         end else begin : g_right
            assign right_src = cell_q[gi+1];
         end

         assign cell_ctl[gi].load_val   = (ins_ok || upd_ok) && (cell_pos == pos9);
         assign cell_ctl[gi].load_left  = ins_ok && (cell_pos > pos9);
         assign cell_ctl[gi].load_right = del_ok && (cell_pos >= pos9);
         assign hit_vec[gi] = cell_match[gi] && (cell_pos <= cnt9);

         plst_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[gi]),
            .value_in   (req_value_in),
            .left_data  (left_src),
            .right_data (right_src),
            .key        (req_value_in),
            .data       (cell_q[gi]),
            .match      (cell_match[gi])
         );
      end
   endgenerate

   // lowest matching cell wins
   always_comb begin
      first_hit = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            first_hit = POS_W'(i);
         end
      end
   end
   assign any_hit = |hit_vec;

   always_comb begin
      status_in    = ST_OK;
      value_out_in = '0;
      found_in     = '0;
      count_in     = count_ff;
      case (req_mode)
         MODE_INSERT: begin
            if (ins_bad) begin
               status_in = ST_BAD_POS;
            end else if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         MODE_DELETE: begin
            if (rd_bad) begin
               status_in = ST_BAD_POS;
            end else begin
               value_out_in = cell_q[sel_idx];
               count_in     = count_ff - 1'b1;
            end
         end
         MODE_UPDATE: begin
            if (rd_bad) begin
               status_in = ST_BAD_POS;
            end
         end
         MODE_READ: begin
            if (rd_bad) begin
               status_in = ST_BAD_POS;
            end else begin
               value_out_in = cell_q[sel_idx];
            end
         end
         MODE_LOCATE: begin
            if (any_hit) begin
               found_in = first_hit;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         MODE_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         count_ff     <= count_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         value_out_ff <= value_out_in;
         found_ff     <= found_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_value_out      = value_out_ff;
   assign rsp_found_position = found_ff;
   assign rsp_length         = LEN_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length above capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_CLEAR) |=> (rsp_length == '0 && rsp_status == ST_OK))
      else $error("clear did not empty the list");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_INSERT) |=>
         (rsp_status != ST_OK || count_ff == $past(count_ff) + 1'b1))
      else $error("successful insert did not grow the list");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_DELETE) |=>
         (rsp_status != ST_OK || count_ff == $past(count_ff) - 1'b1))
      else $error("successful delete did not shrink the list");

   a_miss_no_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status == ST_NOT_FOUND) |-> (rsp_found_position == '0))
      else $error("not-found result carries an index");

endmodule

// ===== design/plst_cell.sv =====
module plst_cell
   import plst_pkg::*;
(
   input  logic              clock,
   input  plst_cell_ctl_type ctl,
   input  value_type         value_in,
   input  value_type         left_data,
   input  value_type         right_data,
   input  value_type         key,
   output value_type         data,
   output logic              match
);

   value_type data_ff;
   value_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load_val) begin
         data_in = value_in;
      end else if (ctl.load_left) begin
         data_in = left_data;
      end else if (ctl.load_right) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == key);

endmodule

// ===== tb/sv/positional_list_store_core_test.sv =====
`timescale 1ns / 1ps

module positional_list_store_core_test
   import plst_pkg::*;
();

   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
   localparam int IDLE_LIMIT = 1000;
   localparam int MAX_REPORTED = 10;
   localparam value_type ABSENT_KEY = 32'sh0bad_cafe;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      value_type           value_out;
      logic [POS_W-1:0]    found_position;
      logic [LEN_W-1:0]    length;
   } list_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode;
   logic [POS_W-1:0]          req_position;
   logic signed [VALUE_W-1:0] req_value_in;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_value_out;
   logic [POS_W-1:0]          rsp_found_position;
   logic [LEN_W-1:0]          rsp_length;

   // shadow copy of the list, advanced at every accepted request
   value_type       list_cells [CAPACITY];
   int              list_len;
   list_result_type pending_results [$];

   int mismatch_count = 0;
   int idle_cycles = 0;
   int req_gap_max;
   int rsp_hold_max;

   // extremes and alternating bit patterns, reused cyclically so locate sees duplicates
   value_type sample_values [8] = '{
      32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
      32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_0007, 32'sh1234_5678
   };

   positional_list_store_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value_in       (req_value_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_value_out      (rsp_value_out),
      .rsp_found_position (rsp_found_position),
      .rsp_length         (rsp_length)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic list_result_type apply_list_op(input logic [MODE_W-1:0] mode,
         input logic [POS_W-1:0] pos, input value_type val);
      list_result_type r;
      int p;
      int i;
      r = '0;
      r.status = ST_OK;
      p = int'(pos);
      case (mode)
         MODE_INSERT: begin
            if (p < 1 || p > list_len + 1) begin
               r.status = ST_BAD_POS;
            end else if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_len; i >= p; i--) list_cells[i] = list_cells[i - 1];
               list_cells[p - 1] = val;
               list_len++;
            end
         end
         MODE_DELETE: begin
            if (p < 1 || p > list_len) begin
               r.status = ST_BAD_POS;
            end else begin
               r.value_out = list_cells[p - 1];
               for (i = p; i < list_len; i++) list_cells[i - 1] = list_cells[i];
               list_len--;
            end
         end
         MODE_UPDATE: begin
            if (p < 1 || p > list_len) r.status = ST_BAD_POS;
            else list_cells[p - 1] = val;
         end
         MODE_READ: begin
            if (p < 1 || p > list_len) r.status = ST_BAD_POS;
            else r.value_out = list_cells[p - 1];
         end
         MODE_LOCATE: begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < list_len; i++) begin
               if (r.status == ST_NOT_FOUND && list_cells[i] == val) begin
                  r.status = ST_OK;
                  r.found_position = POS_W'(i);
               end
            end
         end
         MODE_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      r.length = LEN_W'(list_len);
      return r;
   endfunction

   task automatic send_list_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
         input value_type val);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value_in <= val;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_list_op(mode, pos, val));
   endtask

   task automatic test_empty_list();
      send_list_op(MODE_INSERT, 8'd0, 32'sh0000_0001);
      send_list_op(MODE_DELETE, 8'd1, 32'sh0000_0000);
      send_list_op(MODE_LOCATE, 8'd0, 32'sh0000_0000);
      send_list_op(MODE_SPARE_6, 8'd1, 32'sh0000_0000);
      send_list_op(MODE_SPARE_7, 8'd255, 32'shffff_ffff);
   endtask

   task automatic test_fill_and_overflow();
      logic [POS_W-1:0] pos;
      int i;
      // front, back and middle inserts
      for (i = 0; i < CAPACITY; i++) begin
         case (i % 3)
            0: pos = 8'd1;
            1: pos = POS_W'(list_len + 1);
            default: pos = POS_W'(list_len / 2 + 1);
         endcase
         send_list_op(MODE_INSERT, pos, sample_values[i % 8]);
      end
      send_list_op(MODE_INSERT, POS_W'(CAPACITY + 1), 32'sh0000_0042);
      // out-of-range position wins over full
      send_list_op(MODE_INSERT, POS_W'(CAPACITY + 2), 32'sh0000_0042);
   endtask

   task automatic test_full_list_access();
      send_list_op(MODE_READ, POS_W'(CAPACITY), 32'sh0000_0000);
      send_list_op(MODE_READ, POS_W'(CAPACITY + 1), 32'sh0000_0000);
      send_list_op(MODE_UPDATE, 8'd0, 32'sh0000_0000);
      send_list_op(MODE_UPDATE, 8'd8, 32'sh7fff_ffff);
      send_list_op(MODE_LOCATE, 8'd0, 32'sh0000_0007);
      send_list_op(MODE_LOCATE, 8'd0, ABSENT_KEY);
      send_list_op(MODE_DELETE, POS_W'(CAPACITY), 32'sh0000_0000);
      send_list_op(MODE_DELETE, 8'd1, 32'sh0000_0000);
      send_list_op(MODE_CLEAR, 8'd0, 32'sh0000_0000);
      send_list_op(MODE_READ, 8'd1, 32'sh0000_0000);
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
      value_type         val;
      int k;
      int roll;
      int ins_w;
      int span;
      for (k = 0; k < n_items; k++) begin
         if (k % 150 == 0) begin
            case ((k / 150) % 4)
               0: begin
                  req_gap_max = 0;
                  rsp_hold_max = 0;
               end
               1: begin
                  req_gap_max = 12;
                  rsp_hold_max = 0;
               end
               2: begin
                  req_gap_max = 0;
                  rsp_hold_max = 12;
               end
               default: begin
                  req_gap_max = 12;
                  rsp_hold_max = 12;
               end
            endcase
         end
         // alternate between filling and draining the list
         ins_w = ((k / 100) % 2 == 0) ? 45 : 15;
         roll = $urandom_range(0, 99);
         if (roll < ins_w) mode = MODE_INSERT;
         else if (roll < 60) mode = MODE_DELETE;
         else if (roll < 68) mode = MODE_UPDATE;
         else if (roll < 78) mode = MODE_READ;
         else if (roll < 92) mode = MODE_LOCATE;
         else if (roll < 94) mode = MODE_CLEAR;
         else mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;

         span = (mode == MODE_INSERT) ? list_len + 1 : list_len;
         roll = $urandom_range(0, 9);
         if (roll < 8 && span > 0) pos = POS_W'($urandom_range(1, span));
         else if (roll < 9) pos = $urandom_range(0, 1) ? 8'd0 : POS_W'(span + 1);
         else pos = POS_W'($urandom_range(0, 255));

         roll = $urandom_range(0, 9);
         if (mode == MODE_LOCATE && list_len > 0 && roll < 7)
            val = list_cells[$urandom_range(0, list_len - 1)];
         else if (roll < 4) val = sample_values[$urandom_range(0, 7)];
         else val = $urandom;

         send_list_op(mode, pos, val);
      end
   endtask

   // response backpressure, drawn once per result transfer
   initial begin : rsp_backpressure
      int hold;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         hold = $urandom_range(0, rsp_hold_max);
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : result_check
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("unexpected result: status %0d value %h found %0d length %0d",
                        rsp_status, rsp_value_out, rsp_found_position, rsp_length);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status || rsp_value_out !== want.value_out ||
                rsp_found_position !== want.found_position ||
                rsp_length !== want.length) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display({"result mismatch: expected status %0d value %h found %0d ",
                            "length %0d, got status %0d value %h found %0d length %0d"},
                           want.status, want.value_out, want.found_position, want.length,
                           rsp_status, rsp_value_out, rsp_found_position, rsp_length);
            end
         end
      end
   end

   // cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = MODE_INSERT;
      req_position = '0;
      req_value_in = '0;
      list_len     = 0;
      req_gap_max  = 12;
      rsp_hold_max = 12;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_fill_and_overflow();
      test_full_list_access();
      test_random_traffic(1900);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
